// ===== hdl/cwm_pkg.sv =====
package cwm_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 1024;

  // input word modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_TOLERANCE = 3'd0;
  localparam logic [2:0] REG_OFFSET_A  = 3'd1;
  localparam logic [2:0] REG_OFFSET_B  = 3'd2;
  localparam logic [2:0] REG_SET_A_ID  = 3'd3;
  localparam logic [2:0] REG_SET_B_ID  = 3'd4;
  localparam logic [2:0] REG_A_SCATTER = 3'd5;
  localparam logic [2:0] REG_B_SCATTER = 3'd6;
  localparam logic [2:0] REG_OVERRIDE  = 3'd7;

  localparam logic [3:0] SET_A_ID_RST = 4'd0;
  localparam logic [3:0] SET_B_ID_RST = 4'd1;
  localparam logic       A_SCATTER_RST = 1'b0;
  localparam logic       B_SCATTER_RST = 1'b1;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned ENERGY_W = 16;
  localparam int unsigned STIME_W = 50;
  localparam int unsigned BOUND_W = 52;

  typedef struct packed {
    logic [31:0] tolerance;
    logic [31:0] offset_a;
    logic [31:0] offset_b;
    logic [3:0]  set_a_id;
    logic [3:0]  set_b_id;
    logic        a_is_scatter;
    logic        b_is_scatter;
    logic        override_type;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic load;
    logic shift;
    logic bound;
    logic rd;
    logic capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic type_ok;
    logic more;
    logic rvalid;
    logic hit;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_BOUND,
    ST_SCAN
  } state_t;

endpackage

// ===== hdl/cwm_ram.sv =====
module cwm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/cwm_cfg.sv =====
module cwm_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cwm_pkg::cfg_t cfg
);
  import cwm_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance     <= '0;
      cfg.offset_a      <= '0;
      cfg.offset_b      <= '0;
      cfg.set_a_id      <= SET_A_ID_RST;
      cfg.set_b_id      <= SET_B_ID_RST;
      cfg.a_is_scatter  <= A_SCATTER_RST;
      cfg.b_is_scatter  <= B_SCATTER_RST;
      cfg.override_type <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_TOLERANCE: cfg.tolerance     <= pwdata;
        REG_OFFSET_A:  cfg.offset_a      <= pwdata;
        REG_OFFSET_B:  cfg.offset_b      <= pwdata;
        REG_SET_A_ID:  cfg.set_a_id      <= pwdata[3:0];
        REG_SET_B_ID:  cfg.set_b_id      <= pwdata[3:0];
        REG_A_SCATTER: cfg.a_is_scatter  <= pwdata[0];
        REG_B_SCATTER: cfg.b_is_scatter  <= pwdata[0];
        REG_OVERRIDE:  cfg.override_type <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TOLERANCE: prdata = cfg.tolerance;
      REG_OFFSET_A:  prdata = cfg.offset_a;
      REG_OFFSET_B:  prdata = cfg.offset_b;
      REG_SET_A_ID:  prdata = {28'd0, cfg.set_a_id};
      REG_SET_B_ID:  prdata = {28'd0, cfg.set_b_id};
      REG_A_SCATTER: prdata = {31'd0, cfg.a_is_scatter};
      REG_B_SCATTER: prdata = {31'd0, cfg.b_is_scatter};
      REG_OVERRIDE:  prdata = {31'd0, cfg.override_type};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== hdl/cwm_ctrl.sv =====
module cwm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         mode,
  input  cwm_pkg::dp_stat_t  stat,
  output cwm_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import cwm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && mode == MODE_QUERY && stat.type_ok) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: state_next = ST_BOUND;
      ST_BOUND: state_next = ST_SCAN;
      ST_SCAN: begin
        if (stat.hit || (!stat.more && !stat.rvalid)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.clear  = start && mode == MODE_CLEAR;
        cmd.append = start && mode == MODE_APPEND;
        cmd.load   = start && mode == MODE_QUERY && stat.type_ok;
      end
      ST_SHIFT: cmd.shift = 1'b1;
      ST_BOUND: begin
        cmd.bound = 1'b1;
        cmd.rd    = stat.more;
      end
      ST_SCAN: begin
        cmd.rd      = stat.more && !stat.hit;
        cmd.capture = stat.hit;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (state == ST_BOUND || state == ST_SCAN))
    else $error("store read outside a scan");
  a_hit_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && stat.hit) |=> (state == ST_IDLE && !busy))
    else $error("scan did not stop on a match");
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && cmd.load) |=> (state == ST_SHIFT && busy))
    else $error("accepted query did not start");
`endif

endmodule

// ===== hdl/cwm_dp.sv =====
module cwm_dp #(
  parameter int unsigned STORE_DEPTH = cwm_pkg::STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cwm_pkg::cfg_t      cfg,
  input  cwm_pkg::ctrl_cmd_t cmd,
  output cwm_pkg::dp_stat_t  stat,
  input  logic [47:0]        event_time,
  input  logic [15:0]        event_energy,
  output logic               strobe,
  output logic [4:0]         first_set,
  output logic [4:0]         second_set,
  output logic [15:0]        energy_a,
  output logic [15:0]        energy_b,
  output logic [49:0]        time_a,
  output logic [49:0]        time_b,
  output logic [31:0]        pair_count
);
  import cwm_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned MW = TIME_W + ENERGY_W;

  logic [CW-1:0]              count;
  logic [CW-1:0]              idx;
  logic                       rvalid;
  logic [MW-1:0]              rdata;
  logic signed [STIME_W-1:0]  ta;
  logic [ENERGY_W-1:0]        ea;
  logic signed [STIME_W:0]    tab;
  logic signed [BOUND_W-1:0]  lo;
  logic signed [BOUND_W-1:0]  hi;
  logic signed [BOUND_W-1:0]  stored;
  logic [TIME_W-1:0]          rtime;
  logic [ENERGY_W-1:0]        renergy;
  logic                       full;
  logic [31:0]                pairs;

  assign full    = (count == CW'(STORE_DEPTH));
  assign rtime   = rdata[MW-1:ENERGY_W];
  assign renergy = rdata[ENERGY_W-1:0];
  // window test against bounds already shifted by -offset_b
  assign stored  = $signed({{(BOUND_W - TIME_W){1'b0}}, rtime});

  assign stat.type_ok = (cfg.a_is_scatter != cfg.b_is_scatter) || cfg.override_type;
  assign stat.more    = (idx < count);
  assign stat.rvalid  = rvalid;
  assign stat.hit     = rvalid && (stored > lo) && (stored < hi);

  cwm_ram #(
    .WIDTH (MW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.append && !full),
    .waddr (count[AW-1:0]),
    .wdata ({event_time, event_energy}),
    .re    (cmd.rd),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      idx    <= '0;
      rvalid <= 1'b0;
      pairs  <= '0;
      strobe <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append && !full) begin
        count <= count + 1'b1;
      end
      if (cmd.shift) begin
        idx <= '0;
      end else if (cmd.rd) begin
        idx <= idx + 1'b1;
      end
      rvalid <= cmd.rd;
      strobe <= cmd.capture;
      if (cmd.capture && pairs != 32'hFFFF_FFFF) begin
        pairs <= pairs + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ta <= $signed({2'b00, event_time}) + $signed({{18{cfg.offset_a[31]}}, cfg.offset_a});
      ea <= event_energy;
    end
    if (cmd.shift) begin
      tab <= $signed({ta[STIME_W-1], ta}) - $signed({{19{cfg.offset_b[31]}}, cfg.offset_b});
    end
    if (cmd.bound) begin
      lo <= $signed({tab[STIME_W], tab}) - $signed({20'd0, cfg.tolerance});
      hi <= $signed({tab[STIME_W], tab}) + $signed({20'd0, cfg.tolerance});
    end
    if (cmd.capture) begin
      first_set  <= {1'b0, cfg.set_a_id} + 5'd1;
      second_set <= {1'b0, cfg.set_b_id} + 5'd1;
      energy_a   <= ea;
      energy_b   <= renergy;
      time_a     <= ta;
      time_b     <= {2'b00, rtime} + {{18{cfg.offset_b[31]}}, cfg.offset_b};
    end
  end

  assign pair_count = pairs;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STORE_DEPTH))
    else $error("store count beyond depth");
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (idx < count))
    else $error("read beyond stored events");
  a_word_counted: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (pairs != 32'd0))
    else $error("pair word with zero count");
`endif

endmodule

// ===== hdl/coincidence_window_matcher.sv =====
// channel   signals                                        handshake
// -------   ---------------------------------------------  ----------------------------
// command   mode, event_time, event_energy                 start high while busy low
// result    first_set, second_set, energy_a/b, time_a/b,   strobe, one cycle, no stall
//           pair_count
// config    psel, penable, pwrite, paddr, pwdata, prdata   apb write, pready tied high
//
// clear and append are taken in idle and may follow back to back
// a query loads, shifts and bounds, then scans the stored events until one
// matches or all are read: one store read per cycle through the event ram
// a matching query raises strobe the cycle after the scan stops
// rst is synchronous; the store needs no clearing pass, only the count resets
module coincidence_window_matcher #(
  parameter int unsigned STORE_DEPTH = cwm_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [47:0] event_time,
  input  logic [15:0] event_energy,
  output logic        strobe,
  output logic [4:0]  first_set,
  output logic [4:0]  second_set,
  output logic [15:0] energy_a,
  output logic [15:0] energy_b,
  output logic [49:0] time_a,
  output logic [49:0] time_b,
  output logic [31:0] pair_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cwm_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  cwm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cwm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cwm_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .event_time   (event_time),
    .event_energy (event_energy),
    .strobe       (strobe),
    .first_set    (first_set),
    .second_set   (second_set),
    .energy_a     (energy_a),
    .energy_b     (energy_b),
    .time_a       (time_a),
    .time_b       (time_b),
    .pair_count   (pair_count)
  );

endmodule
